FILE: hdl/source_flood_detector_top_assert.svh
// Assertion macros used by the source flood detector sequencer.
`ifndef SOURCE_FLOOD_DETECTOR_TOP_ASSERT_SVH
`define SOURCE_FLOOD_DETECTOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SFD_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfd: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfd: next-cycle check failed");

`endif

FILE: hdl/sfd_pkg.sv
// Shared constants and types of the source flood detector.
package sfd_pkg;

  localparam int TABLE_ENTRIES_DEFAULT = 32;

  localparam int WORD_W  = 32;
  localparam int ADDR_W  = 32;
  localparam int COUNT_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX       = 16'hFFFF;
  localparam logic [COUNT_W-1:0] COUNT_ONE       = 16'd1;
  localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 16'd4096;

  // Input kinds carried on the slave tuser bit.
  localparam logic ACT_PACKET = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  // Configuration port: one register word, byte address bit 2 selects it.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_THRESHOLD = 1'b0;

  // Table write and clear strobes from the sequencer.
  typedef struct packed {
    logic ent_we;
    logic rank_we;
    logic clear_all;
  } tbl_ctl_t;

  // Outputs of the shared compare unit.
  typedef struct packed {
    logic eq;
    logic lt;
    logic gt;
  } cmp_res_t;

endpackage

FILE: hdl/sfd_cmp.sv
// Shared compare and increment unit used by the scan, resolve, update and finish steps of the sequencer.
module sfd_cmp (
  input  logic [sfd_pkg::WORD_W-1:0] a,
  input  logic [sfd_pkg::WORD_W-1:0] b,
  output sfd_pkg::cmp_res_t          res,
  output logic [sfd_pkg::WORD_W-1:0] inc
);

  always_comb begin
    res.eq = (a == b);
    res.lt = (a < b);
    res.gt = (a > b);
    inc    = a + sfd_pkg::WORD_W'(1);
  end

endmodule

FILE: hdl/sfd_table.sv
// Entry storage: address, count and rank memories plus per-entry flag bits.
module sfd_table #(
  parameter int TABLE_ENTRIES = sfd_pkg::TABLE_ENTRIES_DEFAULT,
  localparam int IdxW = $clog2(TABLE_ENTRIES)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  sfd_pkg::tbl_ctl_t          ctl,
  input  logic [IdxW-1:0]            rd_idx,
  input  logic [IdxW-1:0]            wr_slot,
  input  logic [sfd_pkg::ADDR_W-1:0] wr_addr,
  input  logic [sfd_pkg::COUNT_W-1:0] wr_count,
  input  logic [IdxW-1:0]            rank_idx,
  input  logic [IdxW-1:0]            rank_val,
  output logic                       ent_valid,
  output logic [sfd_pkg::ADDR_W-1:0] ent_addr,
  output logic [sfd_pkg::COUNT_W-1:0] ent_count,
  output logic [IdxW-1:0]            ent_rank
);

  logic [sfd_pkg::ADDR_W-1:0]  addr_mem  [TABLE_ENTRIES];
  logic [sfd_pkg::COUNT_W-1:0] count_mem [TABLE_ENTRIES];
  logic [IdxW-1:0]             rank_mem  [TABLE_ENTRIES];

  // valid: entry holds a source; live: count written since last clear;
  // ranked: rank written since reset (else rank equals the entry index).
  logic [TABLE_ENTRIES-1:0] valid;
  logic [TABLE_ENTRIES-1:0] live;
  logic [TABLE_ENTRIES-1:0] ranked;

  logic [sfd_pkg::COUNT_W-1:0] count_raw;
  logic [IdxW-1:0]             rank_raw;
  logic [IdxW-1:0]             idx_q;
  logic                        live_q;
  logic                        ranked_q;

  always_ff @(posedge clk) begin
    if (ctl.ent_we) begin
      addr_mem[wr_slot]  <= wr_addr;
      count_mem[wr_slot] <= wr_count;
    end
    if (ctl.rank_we) begin
      rank_mem[rank_idx] <= rank_val;
    end
    ent_addr  <= addr_mem[rd_idx];
    count_raw <= count_mem[rd_idx];
    rank_raw  <= rank_mem[rd_idx];
    ent_valid <= valid[rd_idx];
    live_q    <= live[rd_idx];
    ranked_q  <= ranked[rd_idx];
    idx_q     <= rd_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      live   <= '0;
      ranked <= '0;
    end else begin
      if (ctl.clear_all) begin
        live <= '0;
      end else if (ctl.ent_we) begin
        live[wr_slot] <= 1'b1;
      end
      if (ctl.ent_we) begin
        valid[wr_slot] <= 1'b1;
      end
      if (ctl.rank_we) begin
        ranked[rank_idx] <= 1'b1;
      end
    end
  end

  assign ent_count = live_q ? count_raw : '0;
  assign ent_rank  = ranked_q ? rank_raw : idx_q;

endmodule

FILE: hdl/sfd_ctrl.sv
// Sequencer: scan pass, entry update, rank update pass and result register.
`include "source_flood_detector_top_assert.svh"

module sfd_ctrl #(
  parameter int TABLE_ENTRIES = sfd_pkg::TABLE_ENTRIES_DEFAULT,
  localparam int IdxW = $clog2(TABLE_ENTRIES)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [sfd_pkg::COUNT_W-1:0] threshold,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [sfd_pkg::ADDR_W-1:0]  in_addr,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sfd_pkg::COUNT_W-1:0] out_count,
  output logic                        out_present,
  output logic                        out_evicted,
  output logic                        out_attacker,
  output sfd_pkg::tbl_ctl_t           tbl_ctl,
  output logic [IdxW-1:0]             rd_idx,
  output logic [IdxW-1:0]             wr_slot,
  output logic [sfd_pkg::ADDR_W-1:0]  wr_addr,
  output logic [sfd_pkg::COUNT_W-1:0] wr_count,
  output logic [IdxW-1:0]             rank_idx,
  output logic [IdxW-1:0]             rank_val,
  input  logic                        ent_valid,
  input  logic [sfd_pkg::ADDR_W-1:0]  ent_addr,
  input  logic [sfd_pkg::COUNT_W-1:0] ent_count,
  input  logic [IdxW-1:0]             ent_rank
);

  localparam logic [IdxW-1:0] LAST = IdxW'(TABLE_ENTRIES - 1);
  localparam int PadRank  = sfd_pkg::WORD_W - IdxW;
  localparam int PadCount = sfd_pkg::WORD_W - sfd_pkg::COUNT_W;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_SCAN    = 5'b00010,
    S_RESOLVE = 5'b00100,
    S_UPDATE  = 5'b01000,
    S_FINISH  = 5'b10000
  } state_t;

  state_t state;

  logic [IdxW-1:0]             idx;
  logic                        iss;
  logic                        pend;
  logic [IdxW-1:0]             pidx;
  logic [sfd_pkg::ADDR_W-1:0]  key;
  logic                        hit;
  logic [IdxW-1:0]             hit_slot;
  logic [IdxW-1:0]             hit_rank;
  logic [sfd_pkg::COUNT_W-1:0] cur_count;
  logic [IdxW-1:0]             lru_slot;
  logic                        lru_valid;
  logic [IdxW-1:0]             slot;
  logic [IdxW-1:0]             old_rank;
  logic [sfd_pkg::COUNT_W-1:0] count_res;
  logic                        evict;

  logic [sfd_pkg::WORD_W-1:0]  op_a;
  logic [sfd_pkg::WORD_W-1:0]  op_b;
  sfd_pkg::cmp_res_t           cmp;
  logic [sfd_pkg::WORD_W-1:0]  cmp_inc;

  logic                        accept;
  logic                        out_free;
  logic [IdxW-1:0]             slot_sel;
  logic [sfd_pkg::COUNT_W-1:0] count_new;

  sfd_cmp u_cmp (
    .a   (op_a),
    .b   (op_b),
    .res (cmp),
    .inc (cmp_inc)
  );

  // Route the shared unit's operands by step.
  always_comb begin
    unique case (state)
      S_UPDATE: begin
        op_a = {{PadRank{1'b0}}, ent_rank};
        op_b = {{PadRank{1'b0}}, old_rank};
      end
      S_RESOLVE: begin
        op_a = {{PadCount{1'b0}}, cur_count};
        op_b = {{PadCount{1'b0}}, sfd_pkg::COUNT_MAX};
      end
      S_FINISH: begin
        op_a = {{PadCount{1'b0}}, count_res};
        op_b = {{PadCount{1'b0}}, threshold};
      end
      default: begin
        op_a = key;
        op_b = ent_addr;
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign slot_sel  = hit ? hit_slot : lru_slot;
  assign count_new = !hit ? sfd_pkg::COUNT_ONE
                   : (cmp.eq ? sfd_pkg::COUNT_MAX : cmp_inc[sfd_pkg::COUNT_W-1:0]);

  always_comb begin
    tbl_ctl.ent_we    = (state == S_RESOLVE);
    tbl_ctl.rank_we   = (state == S_UPDATE) && pend;
    tbl_ctl.clear_all = accept && (in_action == sfd_pkg::ACT_CLEAR);
    rd_idx   = idx;
    wr_slot  = slot_sel;
    wr_addr  = key;
    wr_count = count_new;
    rank_idx = pidx;
    if (pidx == slot) begin
      rank_val = '0;
    end else if (cmp.lt) begin
      rank_val = cmp_inc[IdxW-1:0];
    end else begin
      rank_val = ent_rank;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      iss       <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= iss;
      pidx <= idx;
      if (iss) begin
        if (idx == LAST) begin
          iss <= 1'b0;
        end else begin
          idx <= idx + IdxW'(1);
        end
      end
      // Drop the result once taken, unless a new one loads in this cycle.
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            key <= in_addr;
            hit <= 1'b0;
            if (in_action == sfd_pkg::ACT_CLEAR) begin
              count_res <= '0;
              evict     <= 1'b0;
              state     <= S_FINISH;
            end else begin
              idx   <= '0;
              iss   <= 1'b1;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (pend) begin
            if (ent_valid && cmp.eq && !hit) begin
              hit       <= 1'b1;
              hit_slot  <= pidx;
              hit_rank  <= ent_rank;
              cur_count <= ent_count;
            end
            if (ent_rank == LAST) begin
              lru_slot  <= pidx;
              lru_valid <= ent_valid;
            end
            if (pidx == LAST) begin
              state <= S_RESOLVE;
            end
          end
        end
        S_RESOLVE: begin
          slot      <= slot_sel;
          old_rank  <= hit ? hit_rank : LAST;
          count_res <= count_new;
          evict     <= !hit && lru_valid;
          idx       <= '0;
          iss       <= 1'b1;
          state     <= S_UPDATE;
        end
        S_UPDATE: begin
          if (pend && (pidx == LAST)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          // Hold the result until the output register frees up.
          if (out_free) begin
            out_valid    <= 1'b1;
            out_count    <= count_res;
            out_present  <= hit;
            out_evicted  <= evict;
            out_attacker <= cmp.gt;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SFD_ASSERT_NEXT(a_hit_no_evict, clk, rst, (state == S_RESOLVE) && hit, !evict)
  `SFD_ASSERT_NEXT(a_count_nonzero, clk, rst, state == S_RESOLVE, count_res != '0)
  `SFD_ASSERT_NEXT(a_update_ends, clk, rst,
                   (state == S_UPDATE) && pend && (pidx == LAST), state == S_FINISH)
  `SFD_ASSERT_NEXT(a_result_loaded, clk, rst, (state == S_FINISH) && out_free,
                   out_valid && (state == S_IDLE))

endmodule

FILE: hdl/source_flood_detector_top.sv
// Top level of the source flood detector: stream ports, register port, table.
//
// Slave stream: one transaction per event. s_tuser[0] is the kind (packet or
// clear), s_tdata carries the IPv4 source address. Master stream: one
// transaction per event with the source's updated count in m_tdata and the
// hit, eviction and attacker flags in m_tuser.
// A packet event walks the whole table twice through one shared compare
// unit: a lookup pass and a recency update pass, one entry per cycle each.
// The result is valid once both passes are done, and s_tready rises in
// that same cycle, so a new packet is only taken after the last one's
// result has loaded. A clear event skips both passes and goes straight to
// the result step: all counts drop at once through per-entry flag bits.
// A finished result sits in the output register; the next event is taken
// while it waits. If m_tready stays low, the following result holds in the
// sequencer and s_tready stays low until the register frees up.
// Reset empties the table, restores the recency order and loads the attack
// threshold with its default; no clearing pass is needed.
// The threshold register sits at byte address 0 of the APB-style port.
module source_flood_detector_top #(
  parameter int TABLE_ENTRIES = sfd_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [31:0]                    s_tdata,   // [31:0] source_address
  input  logic [0:0]                     s_tuser,   // [0] action
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [15:0]                    m_tdata,   // [15:0] packet_count
  output logic [2:0]                     m_tuser,   // [0] was_present [1] evicted
                                                    // [2] attacker
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sfd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sfd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sfd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int IdxW = $clog2(TABLE_ENTRIES);
  localparam int PadThr = sfd_pkg::CFG_DATA_W - sfd_pkg::COUNT_W;

  logic [sfd_pkg::COUNT_W-1:0] threshold;
  logic                        reg_hit;

  sfd_pkg::tbl_ctl_t           tbl_ctl;
  logic [IdxW-1:0]             rd_idx;
  logic [IdxW-1:0]             wr_slot;
  logic [sfd_pkg::ADDR_W-1:0]  wr_addr;
  logic [sfd_pkg::COUNT_W-1:0] wr_count;
  logic [IdxW-1:0]             rank_idx;
  logic [IdxW-1:0]             rank_val;
  logic                        ent_valid;
  logic [sfd_pkg::ADDR_W-1:0]  ent_addr;
  logic [sfd_pkg::COUNT_W-1:0] ent_count;
  logic [IdxW-1:0]             ent_rank;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[sfd_pkg::CFG_ADDR_W-1:2] == sfd_pkg::REG_THRESHOLD);
  assign prdata  = reg_hit ? {{PadThr{1'b0}}, threshold} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= sfd_pkg::THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      threshold <= pwdata[sfd_pkg::COUNT_W-1:0];
    end
  end

  sfd_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .threshold    (threshold),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_action    (s_tuser[0]),
    .in_addr      (s_tdata),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_count    (m_tdata),
    .out_present  (m_tuser[0]),
    .out_evicted  (m_tuser[1]),
    .out_attacker (m_tuser[2]),
    .tbl_ctl      (tbl_ctl),
    .rd_idx       (rd_idx),
    .wr_slot      (wr_slot),
    .wr_addr      (wr_addr),
    .wr_count     (wr_count),
    .rank_idx     (rank_idx),
    .rank_val     (rank_val),
    .ent_valid    (ent_valid),
    .ent_addr     (ent_addr),
    .ent_count    (ent_count),
    .ent_rank     (ent_rank)
  );

  sfd_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .ctl       (tbl_ctl),
    .rd_idx    (rd_idx),
    .wr_slot   (wr_slot),
    .wr_addr   (wr_addr),
    .wr_count  (wr_count),
    .rank_idx  (rank_idx),
    .rank_val  (rank_val),
    .ent_valid (ent_valid),
    .ent_addr  (ent_addr),
    .ent_count (ent_count),
    .ent_rank  (ent_rank)
  );

endmodule

FILE: verif/tb_source_flood_detector_top.sv
// Self-checking testbench of the source flood detector: predicts each result from a table model.
module tb_source_flood_detector_top;
  import sfd_pkg::*;

  localparam int ENTRIES = TABLE_ENTRIES_DEFAULT;
  localparam int RANK_W = $clog2(ENTRIES);
  localparam logic [RANK_W-1:0] LAST_RANK = RANK_W'(ENTRIES - 1);
  localparam logic [CFG_ADDR_W-1:0] THRESHOLD_ADDR = {REG_THRESHOLD, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR = {~REG_THRESHOLD, 2'b00};
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 2 * ENTRIES + 16;
  localparam int POOL_SIZE = 64;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               present;
    logic               evicted;
    logic               attacker;
  } flood_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [31:0]           s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [15:0]           m_tdata;
  logic [2:0]            m_tuser;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Table model
  logic [ADDR_W-1:0]  src_addr  [ENTRIES];
  logic [COUNT_W-1:0] src_count [ENTRIES];
  logic               src_valid [ENTRIES];
  logic [RANK_W-1:0]  src_rank  [ENTRIES];
  logic [COUNT_W-1:0] alarm_level;

  flood_result_t pending_results[$];
  logic [31:0]   src_pool [POOL_SIZE];

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int stall_cycles = 0;
  int cycle_count = 0;
  int mismatch_count = 0;
  int n_events = 0, n_clears = 0, n_hits = 0, n_evictions = 0, n_attacks = 0;
  int n_thresholds = 0;

  source_flood_detector_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("source_flood_detector_top test failed");
      $finish;
    end
  end

  function automatic void reset_source_table();
    for (int i = 0; i < ENTRIES; i++) begin
      src_addr[i]  = '0;
      src_count[i] = '0;
      src_valid[i] = 1'b0;
      src_rank[i]  = RANK_W'(i);
    end
    alarm_level = THRESHOLD_RESET;
  endfunction

  function automatic flood_result_t update_source_table(input logic act,
                                                        input logic [31:0] addr);
    flood_result_t r;
    int slot;
    logic hit;
    logic [RANK_W-1:0] old_rank;
    r = '0;
    if (act == ACT_CLEAR) begin
      // Counts drop; addresses, valid bits and recency order stay.
      for (int i = 0; i < ENTRIES; i++) src_count[i] = '0;
      return r;
    end
    hit = 1'b0;
    slot = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!hit && src_valid[i] && src_addr[i] == addr) begin
        slot = i;
        hit = 1'b1;
      end
    end
    if (hit) begin
      if (src_count[slot] != COUNT_MAX) src_count[slot] = src_count[slot] + 1'b1;
    end else begin
      for (int i = 0; i < ENTRIES; i++)
        if (src_rank[i] == LAST_RANK) slot = i;
      r.evicted = src_valid[slot];
      src_addr[slot]  = addr;
      src_count[slot] = COUNT_ONE;
      src_valid[slot] = 1'b1;
    end
    old_rank = src_rank[slot];
    for (int i = 0; i < ENTRIES; i++)
      if (src_rank[i] < old_rank) src_rank[i] = src_rank[i] + 1'b1;
    src_rank[slot] = '0;
    r.count    = src_count[slot];
    r.present  = hit;
    r.attacker = src_count[slot] > alarm_level;
    return r;
  endfunction

  function automatic logic [31:0] pick_source(input int hot);
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return src_pool[$urandom_range(0, hot - 1)];
    if (r < 95) return $urandom;
    return r[0] ? 32'hFFFF_FFFF : 32'h0;
  endfunction

  // Offer one event; the expectation is recorded at the accepting edge.
  task automatic send_event(input logic act, input logic [31:0] addr);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= addr;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(update_source_table(act, addr));
    n_events++;
    if (act == ACT_CLEAR) n_clears++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [15:0] value);
    logic [15:0] upper;
    upper = 16'($urandom);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {upper, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (addr == THRESHOLD_ADDR) begin
      alarm_level = value;
      n_thresholds++;
    end
  endtask

  task automatic check_threshold_readback();
    logic [CFG_DATA_W-1:0] data;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= THRESHOLD_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (data[15:0] !== alarm_level) begin
      if (mismatch_count < 10)
        $display("threshold readback: expected %0d, got %0d", alarm_level, data[15:0]);
      mismatch_count++;
    end
  endtask

  task automatic set_threshold(input logic [15:0] value);
    wait_idle();
    write_reg(THRESHOLD_ADDR, value);
    check_threshold_readback();
  endtask

  // Receiver: random stall per transaction, plus a long hold-off on request.
  initial begin
    int gap;
    wait (!rst);
    @(posedge clk);
    forever begin
      gap = rx_idle_on ? $urandom_range(0, 3) : 0;
      if (stall_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (stall_cycles) @(posedge clk);
        stall_cycles = 0;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    flood_result_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got = '{count: m_tdata, present: m_tuser[0], evicted: m_tuser[1],
              attacker: m_tuser[2]};
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: count %0d present %0b evicted %0b attacker %0b",
                   got.count, got.present, got.evicted, got.attacker);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        n_hits      += want.present;
        n_evictions += want.evicted;
        n_attacks   += want.attacker;
        if (got.count !== want.count || got.present !== want.present ||
            got.evicted !== want.evicted || got.attacker !== want.attacker) begin
          if (mismatch_count < 10)
            $display({"result mismatch: expected count %0d present %0b evicted %0b ",
                      "attacker %0b, got count %0d present %0b evicted %0b attacker %0b"},
                     want.count, want.present, want.evicted, want.attacker,
                     got.count, got.present, got.evicted, got.attacker);
          mismatch_count++;
        end
      end
    end
  end

  // Misses, hits, clears with stray addresses, and a hit after clear.
  task automatic test_basic_events();
    check_threshold_readback();
    send_event(ACT_PACKET, 32'h0000_0000);
    send_event(ACT_PACKET, 32'h0000_0000);
    send_event(ACT_PACKET, 32'hFFFF_FFFF);
    send_event(ACT_PACKET, 32'hFFFF_FFFF);
    send_event(ACT_PACKET, 32'hA5A5_A5A5);
    send_event(ACT_CLEAR,  32'h1234_5678);
    send_event(ACT_PACKET, 32'h0000_0000);
    send_event(ACT_CLEAR,  32'hFFFF_FFFF);
    send_event(ACT_PACKET, 32'h5A5A_5A5A);
    send_event(ACT_PACKET, 32'hA5A5_A5A5);
    wait_idle();
  endtask

  // Thresholds at and next to both ends of the range, and a write to an unused address.
  task automatic test_threshold_extremes();
    set_threshold(16'd0);
    send_event(ACT_PACKET, 32'h0A00_0001);
    send_event(ACT_PACKET, 32'h0000_0000);
    set_threshold(16'hFFFF);
    send_event(ACT_PACKET, 32'h0A00_0001);
    set_threshold(16'd1);
    send_event(ACT_PACKET, 32'hFFFF_FFFF);
    send_event(ACT_PACKET, 32'hFFFF_FFFF);
    wait_idle();
    write_reg(SPARE_ADDR, 16'd7);
    check_threshold_readback();
    send_event(ACT_PACKET, 32'hFFFF_FFFF);
    set_threshold(16'd65534);
    send_event(ACT_PACKET, 32'h0A00_0001);
    set_threshold(THRESHOLD_RESET);
    send_event(ACT_PACKET, 32'hC0A8_0101);
    wait_idle();
  endtask

  // Cycle through more sources than the table holds so the oldest keeps leaving.
  task automatic test_lru_eviction();
    set_threshold(16'($urandom_range(1, 3)));
    for (int round = 0; round < 3; round++)
      for (int i = 8; i < 8 + ENTRIES + 8; i++)
        send_event(ACT_PACKET, src_pool[i]);
    wait_idle();
  endtask

  // Hold the output off long enough that the input backs up.
  task automatic test_output_backpressure();
    set_threshold(16'($urandom_range(1, 6)));
    stall_cycles = 20 * ENTRIES;
    for (int i = 0; i < 16; i++)
      send_event(($urandom_range(0, 9) == 0) ? ACT_CLEAR : ACT_PACKET, pick_source(12));
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int hot;
    logic [15:0] level;
    for (int p = 0; p < 8; p++) begin
      case (p)
        3:       level = 16'hFFFF;
        5:       level = 16'd0;
        6:       level = 16'($urandom);
        default: level = 16'($urandom_range(1, 24));
      endcase
      set_threshold(level);
      tx_idle_on = (p != 2) && (p != 7);
      rx_idle_on = (p != 4) && (p != 7);
      hot = $urandom_range(4, 48);
      for (int i = 0; i < 160; i++)
        send_event(($urandom_range(0, 99) < 3) ? ACT_CLEAR : ACT_PACKET, pick_source(hot));
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    wait_idle();
  endtask

  initial begin
    reset_source_table();
    src_pool[0] = 32'h0000_0000;
    src_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) src_pool[i] = $urandom;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_events();
    test_threshold_extremes();
    test_lru_eviction();
    test_output_backpressure();
    test_random_traffic();

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d events with %0d clears, %0d repeat sources, %0d evictions,",
             n_events, n_clears, n_hits, n_evictions);
    $display("%0d attacker flags over %0d threshold settings, %0d mismatches",
             n_attacks, n_thresholds, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("source_flood_detector_top test passed");
    end else begin
      $display("source_flood_detector_top test failed");
    end
    $finish;
  end

endmodule

FILE: source_flood_detector_top.f
+incdir+hdl
hdl/sfd_pkg.sv
hdl/sfd_cmp.sv
hdl/sfd_table.sv
hdl/sfd_ctrl.sv
hdl/source_flood_detector_top.sv
verif/tb_source_flood_detector_top.sv
